[design/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros
// assertion helpers used by the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PSD_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed: label");

// antecedent implies consequent in the next cycle
`define PSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed: label");

`endif

[design/psd_pkg.sv]
// ---------------------------------------------------------------------------
// psd_pkg
// types and widths shared by the point to segment distance pipeline
// ---------------------------------------------------------------------------
`default_nettype none

package psd_pkg;

  localparam int CW   = 16;          // coordinate width
  localparam int DW   = 17;          // distance and limit width
  localparam int TB   = 16;          // projection fraction bits
  localparam int DFW  = CW + 1;      // coordinate difference width
  localparam int PW   = 2 * DFW;     // product width
  localparam int LW   = 2 * CW + 2;  // squared length width
  localparam int SW   = 2 * CW + 3;  // signed dot product width
  localparam int RW   = CW + 2;      // residual vector width
  localparam int MW   = 2 * RW;      // squared distance width
  localparam int QW   = RW;          // root width
  localparam int REMW = QW + 4;      // root remainder width
  localparam int NDIV = TB;
  localparam int NSQ  = MW / 2;
  localparam int NST  = 3 + NDIV + 4 + NSQ + 1;

  typedef struct packed {
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
    logic [DW-1:0]        hit_limit;
  } in_item_t;

  typedef struct packed {
    logic [DW-1:0] distance;
    logic          within_res;
    logic          degenerate;
  } out_item_t;

  typedef enum logic [1:0] {
    PROJ_NEAR_A,
    PROJ_NEAR_B,
    PROJ_INSIDE
  } proj_t;

  typedef struct packed {
    logic signed [DFW-1:0] dx;
    logic signed [DFW-1:0] dy;
    logic signed [DFW-1:0] ex;
    logic signed [DFW-1:0] ey;
    proj_t                 proj;
    logic                  degen;
    logic [DW-1:0]         limit;
  } ctx_t;

  typedef struct packed {
    logic          degen;
    logic [DW-1:0] limit;
  } sq_ctx_t;

endpackage

`default_nettype wire

[design/psd_front.sv]
// ---------------------------------------------------------------------------
// psd_front
// differences, products, squared length, dot product and clamp decision
// ---------------------------------------------------------------------------
`default_nettype none

module psd_front (
  input  wire logic              clk,
  input  wire logic              adv,
  input  wire psd_pkg::in_item_t query,
  output psd_pkg::ctx_t          ctx,
  output logic [psd_pkg::LW-1:0] len,
  output logic [psd_pkg::LW-1:0] rem
);

  psd_pkg::ctx_t c1, c2, ctx_next;
  logic signed [psd_pkg::PW-1:0] pdx, pdy, pex, pey;
  logic signed [psd_pkg::SW-1:0] dot;
  logic [psd_pkg::LW-1:0] len_next;

  // stage 1: differences
  always_ff @(posedge clk) begin
    if (adv) begin
      c1.dx    <= $signed({query.end_x[psd_pkg::CW-1], query.end_x})
                - $signed({query.start_x[psd_pkg::CW-1], query.start_x});
      c1.dy    <= $signed({query.end_y[psd_pkg::CW-1], query.end_y})
                - $signed({query.start_y[psd_pkg::CW-1], query.start_y});
      c1.ex    <= $signed({query.point_x[psd_pkg::CW-1], query.point_x})
                - $signed({query.start_x[psd_pkg::CW-1], query.start_x});
      c1.ey    <= $signed({query.point_y[psd_pkg::CW-1], query.point_y})
                - $signed({query.start_y[psd_pkg::CW-1], query.start_y});
      c1.proj  <= psd_pkg::PROJ_NEAR_A;
      c1.degen <= 1'b0;
      c1.limit <= query.hit_limit;
    end
  end

  // stage 2: products
  always_ff @(posedge clk) begin
    if (adv) begin
      pdx <= c1.dx * c1.dx;
      pdy <= c1.dy * c1.dy;
      pex <= c1.ex * c1.dx;
      pey <= c1.ey * c1.dy;
      c2  <= c1;
    end
  end

  // stage 3: sums and clamp
  always_comb begin
    len_next = psd_pkg::LW'(pdx) + psd_pkg::LW'(pdy);
    dot      = psd_pkg::SW'(pex) + psd_pkg::SW'(pey);
    ctx_next = c2;
    ctx_next.degen = (len_next == '0);
    if (ctx_next.degen || dot <= 0) begin
      ctx_next.proj = psd_pkg::PROJ_NEAR_A;
    end else if ($unsigned(dot) >= psd_pkg::SW'(len_next)) begin
      ctx_next.proj = psd_pkg::PROJ_NEAR_B;
    end else begin
      ctx_next.proj = psd_pkg::PROJ_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx <= ctx_next;
      len <= len_next;
      rem <= dot[psd_pkg::LW-1:0];
    end
  end

endmodule

`default_nettype wire

[design/psd_div_stage.sv]
// ---------------------------------------------------------------------------
// psd_div_stage
// one restoring division step of the projection fraction
// ---------------------------------------------------------------------------
`default_nettype none

module psd_div_stage (
  input  wire logic              clk,
  input  wire logic              adv,
  input  wire psd_pkg::ctx_t     ctx_in,
  input  wire logic [psd_pkg::LW-1:0] len_in,
  input  wire logic [psd_pkg::LW-1:0] rem_in,
  input  wire logic [psd_pkg::TB-1:0] t_in,
  output psd_pkg::ctx_t          ctx,
  output logic [psd_pkg::LW-1:0] len,
  output logic [psd_pkg::LW-1:0] rem,
  output logic [psd_pkg::TB-1:0] t
);

  logic [psd_pkg::LW:0] r2, diff;
  logic ge;

  always_comb begin
    r2   = {rem_in, 1'b0};
    ge   = (r2 >= {1'b0, len_in});
    diff = r2 - {1'b0, len_in};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem <= ge ? diff[psd_pkg::LW-1:0] : r2[psd_pkg::LW-1:0];
      t   <= {t_in[psd_pkg::TB-2:0], ge};
      len <= len_in;
      ctx <= ctx_in;
    end
  end

endmodule

`default_nettype wire

[design/psd_back.sv]
// ---------------------------------------------------------------------------
// psd_back
// offset along the segment, residual vector and its squared length
// ---------------------------------------------------------------------------
`default_nettype none

module psd_back (
  input  wire logic              clk,
  input  wire logic              adv,
  input  wire psd_pkg::ctx_t     ctx_in,
  input  wire logic [psd_pkg::TB-1:0] t_in,
  output psd_pkg::sq_ctx_t       sctx,
  output logic [psd_pkg::MW-1:0] mag
);

  localparam logic signed [psd_pkg::PW-1:0] HALF = psd_pkg::PW'(1) <<< (psd_pkg::TB - 1);

  psd_pkg::ctx_t c1, c2;
  psd_pkg::sq_ctx_t c3;
  logic signed [psd_pkg::PW-1:0] ox, oy, rx_full, ry_full;
  logic signed [psd_pkg::RW-1:0] offx, offy, ex_w, ey_w, dx_w, dy_w;
  logic signed [psd_pkg::RW-1:0] rx, ry, rx_next, ry_next;
  logic signed [psd_pkg::MW-1:0] sx, sy;

  function automatic logic signed [psd_pkg::PW-1:0] c1_dx_t(
    input logic signed [psd_pkg::DFW-1:0] d,
    input logic [psd_pkg::TB-1:0] tv
  );
    logic signed [psd_pkg::DFW:0] ts;
    ts = $signed({1'b0, tv});
    return psd_pkg::PW'(d * ts);
  endfunction

  // stage 1: offset products
  always_ff @(posedge clk) begin
    if (adv) begin
      ox <= c1_dx_t(ctx_in.dx, t_in);
      oy <= c1_dx_t(ctx_in.dy, t_in);
      c1 <= ctx_in;
    end
  end

  // stage 2: round the offset and select the residual
  always_comb begin
    rx_full = (ox + HALF) >>> psd_pkg::TB;
    ry_full = (oy + HALF) >>> psd_pkg::TB;
    offx = rx_full[psd_pkg::RW-1:0];
    offy = ry_full[psd_pkg::RW-1:0];
    ex_w = psd_pkg::RW'(c1.ex);
    ey_w = psd_pkg::RW'(c1.ey);
    dx_w = psd_pkg::RW'(c1.dx);
    dy_w = psd_pkg::RW'(c1.dy);
    case (c1.proj)
      psd_pkg::PROJ_INSIDE: begin
        rx_next = ex_w - offx;
        ry_next = ey_w - offy;
      end
      psd_pkg::PROJ_NEAR_B: begin
        rx_next = ex_w - dx_w;
        ry_next = ey_w - dy_w;
      end
      default: begin
        rx_next = ex_w;
        ry_next = ey_w;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rx <= rx_next;
      ry <= ry_next;
      c2 <= c1;
    end
  end

  // stage 3: squares
  always_ff @(posedge clk) begin
    if (adv) begin
      sx <= rx * rx;
      sy <= ry * ry;
      c3 <= '{degen: c2.degen, limit: c2.limit};
    end
  end

  // stage 4: sum of squares
  always_ff @(posedge clk) begin
    if (adv) begin
      mag  <= $unsigned(sx) + $unsigned(sy);
      sctx <= c3;
    end
  end

endmodule

`default_nettype wire

[design/psd_sqrt_stage.sv]
// ---------------------------------------------------------------------------
// psd_sqrt_stage
// one digit of the integer square root, two radicand bits per step
// ---------------------------------------------------------------------------
`default_nettype none

module psd_sqrt_stage (
  input  wire logic                clk,
  input  wire logic                adv,
  input  wire psd_pkg::sq_ctx_t    sctx_in,
  input  wire logic [psd_pkg::REMW-1:0] rem_in,
  input  wire logic [psd_pkg::QW-1:0]   root_in,
  input  wire logic [psd_pkg::MW-1:0]   xs_in,
  output psd_pkg::sq_ctx_t         sctx,
  output logic [psd_pkg::REMW-1:0] rem,
  output logic [psd_pkg::QW-1:0]   root,
  output logic [psd_pkg::MW-1:0]   xs
);

  logic [psd_pkg::REMW-1:0] rem_s, trial;
  logic ge;

  always_comb begin
    rem_s = {rem_in[psd_pkg::REMW-3:0], xs_in[psd_pkg::MW-1:psd_pkg::MW-2]};
    trial = psd_pkg::REMW'({root_in, 2'b01});
    ge    = (rem_s >= trial);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem  <= ge ? rem_s - trial : rem_s;
      root <= {root_in[psd_pkg::QW-2:0], ge};
      xs   <= {xs_in[psd_pkg::MW-3:0], 2'b00};
      sctx <= sctx_in;
    end
  end

endmodule

`default_nettype wire

[design/point_segment_distance.sv]
// ---------------------------------------------------------------------------
// point_segment_distance
// distance from a query point to a line segment, with hit flag
// ---------------------------------------------------------------------------
// Fully pipelined: one transaction is accepted every clock while the output
// is not stalled, and each one passes through 42 register stages in all.
// Stages: 3 for differences, products and the clamp
// decision, 16 restoring division steps for the 16-bit projection fraction,
// 4 for offset, residual, squares and their sum, 18 square root digit steps,
// and one output register. The whole pipeline advances together whenever the
// output register is empty or being taken, so a stalled result holds every
// stage in place and nothing is dropped or repeated.
`default_nettype none

`include "assert_macros.svh"

module point_segment_distance (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               query_valid,
  output logic                    query_ready,
  input  wire psd_pkg::in_item_t  query,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output psd_pkg::out_item_t      result
);

  logic adv;
  logic [psd_pkg::NST-1:0] vld;

  // divider chain
  psd_pkg::ctx_t            dctx [0:psd_pkg::NDIV];
  logic [psd_pkg::LW-1:0]   dlen [0:psd_pkg::NDIV];
  logic [psd_pkg::LW-1:0]   drem [0:psd_pkg::NDIV];
  logic [psd_pkg::TB-1:0]   dt   [0:psd_pkg::NDIV];

  // square root chain
  psd_pkg::sq_ctx_t         sctx  [0:psd_pkg::NSQ];
  logic [psd_pkg::REMW-1:0] srem  [0:psd_pkg::NSQ];
  logic [psd_pkg::QW-1:0]   sroot [0:psd_pkg::NSQ];
  logic [psd_pkg::MW-1:0]   sxs   [0:psd_pkg::NSQ];

  logic [psd_pkg::DW-1:0]   dist_sat;

  // global advance: output slot free or leaving
  assign adv          = !vld[psd_pkg::NST-1] || result_ready;
  assign query_ready  = adv;
  assign result_valid = vld[psd_pkg::NST-1];

  // valid bits travel alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[psd_pkg::NST-2:0], query_valid};
    end
  end

  psd_front u_front (
    .clk   (clk),
    .adv   (adv),
    .query (query),
    .ctx   (dctx[0]),
    .len   (dlen[0]),
    .rem   (drem[0])
  );

  assign dt[0] = '0;

  for (genvar i = 0; i < psd_pkg::NDIV; i++) begin : g_div
    psd_div_stage u_div (
      .clk    (clk),
      .adv    (adv),
      .ctx_in (dctx[i]),
      .len_in (dlen[i]),
      .rem_in (drem[i]),
      .t_in   (dt[i]),
      .ctx    (dctx[i+1]),
      .len    (dlen[i+1]),
      .rem    (drem[i+1]),
      .t      (dt[i+1])
    );
  end

  psd_back u_back (
    .clk    (clk),
    .adv    (adv),
    .ctx_in (dctx[psd_pkg::NDIV]),
    .t_in   (dt[psd_pkg::NDIV]),
    .sctx   (sctx[0]),
    .mag    (sxs[0])
  );

  assign srem[0]  = '0;
  assign sroot[0] = '0;

  for (genvar j = 0; j < psd_pkg::NSQ; j++) begin : g_sqrt
    psd_sqrt_stage u_sqrt (
      .clk     (clk),
      .adv     (adv),
      .sctx_in (sctx[j]),
      .rem_in  (srem[j]),
      .root_in (sroot[j]),
      .xs_in   (sxs[j]),
      .sctx    (sctx[j+1]),
      .rem     (srem[j+1]),
      .root    (sroot[j+1]),
      .xs      (sxs[j+1])
    );
  end

  // saturate the root to the distance width
  always_comb begin
    if (sroot[psd_pkg::NSQ][psd_pkg::QW-1:psd_pkg::DW] != '0) begin
      dist_sat = '1;
    end else begin
      dist_sat = sroot[psd_pkg::NSQ][psd_pkg::DW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      result.distance   <= dist_sat;
      result.within_res <= (dist_sat <= sctx[psd_pkg::NSQ].limit);
      result.degenerate <= sctx[psd_pkg::NSQ].degen;
    end
  end

  // a stall freezes every valid bit
  `PSD_ASSERT_NEXT(a_stall_holds, clk, rst, !adv, $stable(vld))
  // an accepted transaction enters the first stage
  `PSD_ASSERT_NEXT(a_entry, clk, rst, query_valid && query_ready, vld[0])
  // a waiting result keeps the whole pipeline stopped
  `PSD_ASSERT_SAME(a_full_stall, clk, rst, result_valid && !result_ready, !query_ready)

endmodule

`default_nettype wire
